// ===== hw/rtl/multitouch_packet_decoder_unit_assert.svh =====
// assertion macros for the multitouch packet decoder
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef MULTITOUCH_PACKET_DECODER_UNIT_ASSERT_SVH
`define MULTITOUCH_PACKET_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtpd assertion failed");

// next-cycle implication, checked outside reset
`define MTPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtpd assertion failed");

`endif

// ===== hw/rtl/mtpd_pkg.sv =====
// shared types and constants for the multitouch packet decoder
// no dependencies
`timescale 1ns / 1ps

package mtpd_pkg;

    localparam int FINGERS = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] FINGERS_ID  = IDX_W'(FINGERS);
    localparam logic [IDX_W-1:0] LAST_FINGER = IDX_W'(FINGERS - 1);

    // sanity check bits
    localparam logic [7:0] B0_SANITY_MASK = 8'h08;
    localparam logic [7:0] B3_SANITY_MASK = 8'h1c;
    localparam logic [7:0] B3_SANITY_VAL  = 8'h10;

    typedef enum logic [1:0] {
        PK_STATUS  = 2'd0,
        PK_HEAD    = 2'd1,
        PK_MOTION  = 2'd2,
        PK_UNKNOWN = 2'd3
    } t_pkt_kind;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } t_event;

    typedef logic [IDX_W-1:0]  t_fidx;
    typedef logic [FINGERS-1:0] t_fmask;

endpackage

// ===== hw/rtl/multitouch_packet_decoder_unit.sv =====
// throughput: one packet at a time; the next input beat is taken once the last
// result of the current packet sits in the output register
// reset: synchronous, active low; clears masks, finger table and all handshakes
`timescale 1ns / 1ps

// top level of the multitouch packet decoder
// depends on mtpd_pkg and multitouch_packet_decoder_unit_assert.svh
`include "multitouch_packet_decoder_unit_assert.svh"

module multitouch_packet_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // packet input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_byte_0,
    input  logic [7:0]         i_byte_1,
    input  logic [7:0]         i_byte_2,
    input  logic [7:0]         i_byte_3,
    input  logic [7:0]         i_byte_4,
    input  logic [7:0]         i_byte_5,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_packet_status,
    output logic [1:0]         o_event_kind,
    output logic [2:0]         o_finger_index,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [16:0] o_delta_x,
    output logic signed [16:0] o_delta_y,
    output logic               o_last_of_run
);

    // sequencer: one beat is decoded state by state; a single 18-bit adder with
    // saturation serves both head (old minus new) and motion (old plus delta) updates,
    // x in one cycle and y in the next. status packets walk the fingers one per cycle
    // unless a release waits for the output slot, clearing new touches' deltas, emitting releases.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_HEAD_X,
        S_HEAD_Y,
        S_MOT_X,
        S_MOT_Y,
        S_EMIT,
        S_EMPTY
    } t_state;

    t_state r_state;

    // latched packet bytes
    logic [7:0] r_b0, r_b1, r_b2, r_b3, r_b4, r_b5;

    // touch masks
    mtpd_pkg::t_fmask r_mask;
    mtpd_pkg::t_fmask r_prev_mask;

    // finger table, one entry touched per cycle at r_idx
    logic signed [15:0] r_fx [mtpd_pkg::FINGERS];
    logic signed [15:0] r_fy [mtpd_pkg::FINGERS];
    logic signed [16:0] r_fdx [mtpd_pkg::FINGERS];
    logic signed [16:0] r_fdy [mtpd_pkg::FINGERS];

    mtpd_pkg::t_fidx   r_idx;        // finger being worked on
    logic              r_second;     // motion: working on the second finger
    logic              r_down;       // head: this is a touch-down
    logic              r_empty_bad;  // status bit of an event-free result
    mtpd_pkg::t_event  r_ev;

    // output register
    logic               r_out_valid;
    logic               r_status;
    mtpd_pkg::t_event   r_kind;
    mtpd_pkg::t_fidx    r_fidx_out;
    logic signed [15:0] r_px, r_py;
    logic signed [16:0] r_dx, r_dy;
    logic               r_last;

    // decode of the latched packet
    logic [2:0]        id_head;
    logic [2:0]        id_second;
    logic              pkt_bad;
    logic              id_first_ok;
    logic              id_second_ok;
    mtpd_pkg::t_pkt_kind pkt_kind;

    assign pkt_kind     = mtpd_pkg::t_pkt_kind'(r_b3[1:0]);
    assign id_head      = r_b0[7:5];
    assign id_second    = r_b3[7:5];
    assign pkt_bad      = ((r_b0 & mtpd_pkg::B0_SANITY_MASK) != 8'h00)
                       || ((r_b3 & mtpd_pkg::B3_SANITY_MASK) != mtpd_pkg::B3_SANITY_VAL)
                       || (pkt_kind == mtpd_pkg::PK_UNKNOWN);
    assign id_second_ok = (id_second != 3'd0) && (id_second <= mtpd_pkg::FINGERS_ID);
    // head carries its id in byte 3, motion its first id in byte 0
    assign id_first_ok  = (pkt_kind == mtpd_pkg::PK_HEAD) ? id_second_ok
                        : ((id_head != 3'd0) && (id_head <= mtpd_pkg::FINGERS_ID));

    // edges of the touch mask
    mtpd_pkg::t_fmask rising;
    mtpd_pkg::t_fmask falling;
    mtpd_pkg::t_fmask above;
    logic             more_falling;

    assign rising  = r_mask & ~r_prev_mask;
    assign falling = r_prev_mask & ~r_mask;

    always_comb begin
        for (int j = 0; j < mtpd_pkg::FINGERS; j++) begin
            above[j] = (mtpd_pkg::t_fidx'(j) > r_idx);
        end
    end

    assign more_falling = |(falling & above);

    // shared coordinate unit
    logic               is_y;
    logic               is_head;
    logic [11:0]        abs_new;
    logic [7:0]         rel_byte;
    logic signed [16:0] rel_one;
    logic signed [16:0] rel_w;
    logic signed [15:0] coord_old;
    logic signed [16:0] n_opb;
    logic signed [17:0] n_sum;
    logic signed [15:0] n_sat;

    assign is_y      = (r_state == S_HEAD_Y) || (r_state == S_MOT_Y);
    assign is_head   = (r_state == S_HEAD_X) || (r_state == S_HEAD_Y);
    assign abs_new   = is_y ? {r_b4[3:0], r_b5} : {r_b1[3:0], r_b2};
    assign rel_byte  = is_y ? (r_second ? r_b5 : r_b2) : (r_second ? r_b4 : r_b1);
    assign rel_one   = {{9{rel_byte[7]}}, rel_byte};
    // weight bit scales the delta by five
    assign rel_w     = r_b0[4] ? ((rel_one <<< 2) + rel_one) : rel_one;
    assign coord_old = is_y ? r_fy[r_idx] : r_fx[r_idx];
    assign n_opb     = is_head ? -$signed({5'b0, abs_new}) : rel_w;
    assign n_sum     = 18'(coord_old) + 18'(n_opb);

    always_comb begin
        if (n_sum > 18'sd32767) begin
            n_sat = 16'sh7fff;
        end else if (n_sum < -18'sd32768) begin
            n_sat = -16'sh8000;
        end else begin
            n_sat = n_sum[15:0];
        end
    end

    logic slot_free;
    logic out_load;
    assign slot_free = !r_out_valid || i_out_ready;
    // a result beat is loaded into the output register this cycle
    assign out_load  = slot_free && (((r_state == S_SCAN) && falling[r_idx])
                                  || (r_state == S_EMIT) || (r_state == S_EMPTY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_prev_mask <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_second    <= 1'b0;
            r_down      <= 1'b0;
            r_empty_bad <= 1'b0;
            r_ev        <= mtpd_pkg::EV_NONE;
            for (int k = 0; k < mtpd_pkg::FINGERS; k++) begin
                r_fx[k]  <= '0;
                r_fy[k]  <= '0;
                r_fdx[k] <= '0;
                r_fdy[k] <= '0;
            end
        end else begin
            // new result beat, or the current one taken by the sink
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_b0    <= i_byte_0;
                        r_b1    <= i_byte_1;
                        r_b2    <= i_byte_2;
                        r_b3    <= i_byte_3;
                        r_b4    <= i_byte_4;
                        r_b5    <= i_byte_5;
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_second    <= 1'b0;
                    r_empty_bad <= pkt_bad;
                    if (pkt_bad) begin
                        r_state     <= S_EMPTY;
                    end else if (pkt_kind == mtpd_pkg::PK_STATUS) begin
                        r_prev_mask <= r_mask;
                        r_mask      <= r_b1[mtpd_pkg::FINGERS-1:0];
                        r_idx       <= '0;
                        r_state     <= S_SCAN;
                    end else if (!id_first_ok) begin
                        r_state <= S_EMPTY;
                    end else if (pkt_kind == mtpd_pkg::PK_HEAD) begin
                        r_idx   <= id_second - 3'd1;
                        r_state <= S_HEAD_X;
                    end else begin
                        r_idx   <= id_head - 3'd1;
                        r_state <= S_MOT_X;
                    end
                end

                S_SCAN: begin
                    // a release needs the output slot; a new touch only clears
                    if (!falling[r_idx] || slot_free) begin
                        if (rising[r_idx]) begin
                            r_fdx[r_idx] <= '0;
                            r_fdy[r_idx] <= '0;
                        end
                        if (falling[r_idx]) begin
                            r_status    <= 1'b0;
                            r_kind      <= mtpd_pkg::EV_UP;
                            r_fidx_out  <= r_idx;
                            r_px        <= r_fx[r_idx];
                            r_py        <= r_fy[r_idx];
                            r_dx        <= r_fdx[r_idx];
                            r_dy        <= r_fdy[r_idx];
                            r_last      <= !more_falling;
                        end
                        if (r_idx == mtpd_pkg::LAST_FINGER) begin
                            r_state <= (falling == '0) ? S_EMPTY : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end

                S_HEAD_X: begin
                    r_down <= (r_mask[r_idx] != r_prev_mask[r_idx]);
                    r_fx[r_idx] <= $signed({4'b0, abs_new});
                    r_fdx[r_idx] <= (r_mask[r_idx] != r_prev_mask[r_idx])
                                  ? 17'sd0 : n_sum[16:0];
                    r_state <= S_HEAD_Y;
                end

                S_HEAD_Y: begin
                    r_fy[r_idx]  <= $signed({4'b0, abs_new});
                    r_fdy[r_idx] <= r_down ? 17'sd0 : n_sum[16:0];
                    if (r_down) begin
                        r_prev_mask[r_idx] <= 1'b1;
                        r_ev <= mtpd_pkg::EV_DOWN;
                    end else begin
                        r_ev <= mtpd_pkg::EV_MOVE;
                    end
                    r_state <= S_EMIT;
                end

                S_MOT_X: begin
                    r_fx[r_idx]  <= n_sat;
                    r_fdx[r_idx] <= rel_w;
                    r_state      <= S_MOT_Y;
                end

                S_MOT_Y: begin
                    r_fy[r_idx]  <= n_sat;
                    r_fdy[r_idx] <= rel_w;
                    r_ev         <= mtpd_pkg::EV_MOVE;
                    r_state      <= S_EMIT;
                end

                S_EMIT: begin
                    if (slot_free) begin
                        r_status    <= 1'b0;
                        r_kind      <= r_ev;
                        r_fidx_out  <= r_idx;
                        r_px        <= r_fx[r_idx];
                        r_py        <= r_fy[r_idx];
                        r_dx        <= r_fdx[r_idx];
                        r_dy        <= r_fdy[r_idx];
                        // motion with a valid second id goes round once more
                        if (pkt_kind == mtpd_pkg::PK_MOTION && id_second_ok && !r_second) begin
                            r_last   <= 1'b0;
                            r_second <= 1'b1;
                            r_idx    <= id_second - 3'd1;
                            r_state  <= S_MOT_X;
                        end else begin
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_EMPTY: begin
                    if (slot_free) begin
                        r_status    <= r_empty_bad;
                        r_kind      <= mtpd_pkg::EV_NONE;
                        r_fidx_out  <= '0;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_dx        <= '0;
                        r_dy        <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_packet_status = r_status;
    assign o_event_kind    = r_kind;
    assign o_finger_index  = r_fidx_out;
    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_delta_x       = r_dx;
    assign o_delta_y       = r_dy;
    assign o_last_of_run   = r_last;

    // an accepted packet is decoded next, with the input side closed
    `MTPD_ASSERT_NEXT(a_accept_decode, i_in_valid && o_in_ready, (r_state == S_DECODE) && !o_in_ready)
    // the previous mask only moves on decode of a status packet or a head touch-down
    `MTPD_ASSERT_NEXT(a_scan_prev_stable, r_state == S_SCAN, $stable(r_prev_mask))
    // a bad packet never carries an event
    `MTPD_ASSERT_NOW(a_bad_no_event, o_out_valid && o_packet_status, (o_event_kind == mtpd_pkg::EV_NONE) && o_last_of_run)
    // an event-free result closes its run with zero x position and zero y delta
    `MTPD_ASSERT_NOW(a_empty_zero, o_out_valid && (o_event_kind == mtpd_pkg::EV_NONE), o_last_of_run && (o_pos_x == 16'sd0) && (o_delta_y == 17'sd0))

endmodule
